>>> rtl/lbm_pkg.sv
// Package for the LED bar level meter: payload structs, state encodings,
// register indexes and shared constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbm_pkg;

   localparam int DEFAULT_CHANNELS = 4;
   localparam int DEFAULT_MAX_LEDS = 32;
   localparam int MAX_RESULTS      = 4;
   localparam int MASK_W           = 32;

   localparam logic [15:0] FULL_SCALE       = 16'd32768;
   localparam logic [15:0] FULL_NEAR        = 16'd32767;
   localparam logic [7:0]  RESET_HOLD_COUNT = 8'd20;
   localparam logic [5:0]  RESET_LED_COUNT  = 6'd17;
   localparam logic [7:0]  RESET_HOLD_TICKS = 8'd20;
   localparam logic [15:0] RESET_DECAY      = 16'd46341;

   typedef enum logic {
      FUNC_LEVEL = 1'b0,
      FUNC_TICK  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      REG_LED_COUNT  = 2'd0,
      REG_HOLD_TICKS = 2'd1,
      REG_DECAY      = 2'd2,
      REG_ENABLE     = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic        func;
      logic [1:0]  channel;
      logic [15:0] level;
      logic        frame_last;
   } req_type;

   typedef struct packed {
      logic [1:0]        bar_channel;
      logic [MASK_W-1:0] led_on_mask;
      logic [MASK_W-1:0] frame_on_mask;
      logic              last_bar;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  led_count;
      logic [7:0]  hold_ticks;
      logic [15:0] decay_factor;
      logic        meter_enable;
   } cfg_type;

   // one memory word per channel
   typedef struct packed {
      logic [15:0] peak;
      logic [15:0] hold;
      logic [7:0]  countdown;
   } entry_type;

   localparam entry_type RESET_ENTRY = '{peak: FULL_SCALE, hold: FULL_SCALE,
                                         countdown: RESET_HOLD_COUNT};

   typedef struct packed {
      logic start;
   } walk_ctl_type;

   typedef struct packed {
      logic done;
   } walk_sts_type;

   typedef enum logic [1:0] {
      W_IDLE,
      W_STEP,
      W_DECAY
   } walk_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LVL_RD,
      S_EM_START,
      S_EM_RD,
      S_EM_GO,
      S_EM_WALK,
      S_EM_OUT
   } ctl_state_type;

   function automatic logic [15:0] effective(input logic [15:0] v);
      return (v >= FULL_NEAR) ? FULL_SCALE : v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/lbm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [AW-1:0]        waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic                 re,
   input  wire logic [AW-1:0]        raddr,
   output logic      [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/lbm_csr.sv
// Configuration registers of the level meter, written over a valid/ready port.
// Depends on lbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbm_csr
   import lbm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_count    <= RESET_LED_COUNT;
         cfg_ff.hold_ticks   <= RESET_HOLD_TICKS;
         cfg_ff.decay_factor <= RESET_DECAY;
         cfg_ff.meter_enable <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_LED_COUNT:  cfg_ff.led_count    <= csr_wdata[5:0];
            REG_HOLD_TICKS: cfg_ff.hold_ticks   <= csr_wdata[7:0];
            REG_DECAY:      cfg_ff.decay_factor <= csr_wdata;
            REG_ENABLE:     cfg_ff.meter_enable <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/lbm_walk.sv
// Threshold walker: steps the LED thresholds with one 16x16 multiplier,
// building the peak and hold masks, then forms the decayed peak.
// Depends on lbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbm_walk
   import lbm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire walk_ctl_type      ctl,
   input  wire logic [15:0]       peak_eff,
   input  wire logic [15:0]       hold_eff,
   input  wire logic [15:0]       peak_raw,
   input  wire logic [5:0]        leds,
   input  wire logic [15:0]       decay,
   output walk_sts_type           sts,
   output logic [MASK_W-1:0]      led_mask,
   output logic [MASK_W-1:0]      frame_mask,
   output logic [15:0]            peak_decayed
);

   walk_state_type    state_ff, state_in;
   logic [5:0]        cnt_ff;
   logic [5:0]        leds_ff;
   logic [15:0]       t_ff;
   logic [15:0]       pv_ff, hv_ff, pr_ff;
   logic [MASK_W-1:0] led_mask_ff, frame_mask_ff;
   logic [15:0]       decayed_ff;
   logic              done_ff;
   logic [15:0]       mul_a;
   logic [31:0]       prod;
   logic              step_last;

   // the one multiplier: thresholds while stepping, the peak at the end
   assign mul_a     = (state_ff == W_DECAY) ? pr_ff : t_ff;
   assign prod      = mul_a * decay;
   assign step_last = (cnt_ff == leds_ff - 6'd1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         W_IDLE: begin
            if (ctl.start) begin
               state_in = (leds == 6'd0) ? W_DECAY : W_STEP;
            end
         end
         W_STEP: begin
            if (step_last) begin
               state_in = W_DECAY;
            end
         end
         W_DECAY: state_in = W_IDLE;
         default: state_in = W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == W_DECAY);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         W_IDLE: begin
            if (ctl.start) begin
               pv_ff         <= peak_eff;
               hv_ff         <= hold_eff;
               pr_ff         <= peak_raw;
               leds_ff       <= leds;
               t_ff          <= FULL_SCALE;
               cnt_ff        <= 6'd0;
               led_mask_ff   <= '0;
               frame_mask_ff <= '0;
            end
         end
         W_STEP: begin
            led_mask_ff[cnt_ff[4:0]]   <= (pv_ff >= t_ff);
            frame_mask_ff[cnt_ff[4:0]] <= (hv_ff >= t_ff);
            t_ff   <= prod[31:16];
            cnt_ff <= cnt_ff + 6'd1;
         end
         W_DECAY: decayed_ff <= prod[31:16];
         default: ;
      endcase
   end

   assign sts.done     = done_ff;
   assign led_mask     = led_mask_ff;
   assign frame_mask   = frame_mask_ff;
   assign peak_decayed = decayed_ff;

endmodule

`default_nettype wire

>>> rtl/led_bar_level_meter_peak_hold.sv
// Multichannel LED bar level meter with peak hold. Per-channel peak, hold and
// hold countdown live in one small RAM; entries never written read as reset
// values through a valid bit per channel. A level item reads its channel and
// writes it back, followed by an emission when it closes a frame. An
// emission (frame end, or a tick while enabled) visits every channel: read,
// walk the LED thresholds one per cycle on the single multiplier, write back;
// an emission is held while the result channel stalls. Results of the first
// four channels go out in channel order through an output register.
// Depends on lbm_pkg, lbm_ram, lbm_csr, lbm_walk.
`timescale 1ns / 1ps
`default_nettype none

module led_bar_level_meter_peak_hold
   import lbm_pkg::*;
#(
   parameter int CHANNELS = DEFAULT_CHANNELS,
   parameter int MAX_LEDS = DEFAULT_MAX_LEDS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int EMIT_CNT  = (CHANNELS < MAX_RESULTS) ? CHANNELS : MAX_RESULTS;
   localparam logic [AW-1:0] LAST_IDX = AW'(CHANNELS - 1);
   localparam logic [AW-1:0] LAST_EMIT = AW'(EMIT_CNT - 1);
   localparam logic [5:0]    LED_CAP  = 6'(MAX_LEDS);

   cfg_type       cfg;
   ctl_state_type state_ff, state_in;

   logic          tick_ff, last_ff;
   logic [15:0]   level_ff;
   logic [AW-1:0] idx_ff;
   logic [AW-1:0] rd_addr_ff, rd_addr;
   logic [CHANNELS-1:0] valid_ff;
   entry_type     entry_ff, rd_entry, wr_entry;
   logic [$bits(entry_type)-1:0] ram_rdata;
   logic          ram_re, ram_we;
   logic [AW-1:0] ram_waddr;

   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   logic          load_out, out_free, emitted, ch_ok;
   logic [5:0]    leds;
   logic [7:0]    cd_next;

   walk_ctl_type      walk_ctl;
   walk_sts_type      walk_sts;
   logic [MASK_W-1:0] led_mask, frame_mask;
   logic [15:0]       peak_decayed;

   lbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lbm_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CHANNELS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_entry),
      .re    (ram_re),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   assign leds = (cfg.led_count > LED_CAP) ? LED_CAP : cfg.led_count;

   lbm_walk u_walk (
      .clock        (clock),
      .reset        (reset),
      .ctl          (walk_ctl),
      .peak_eff     (effective(entry_ff.peak)),
      .hold_eff     (effective(entry_ff.hold)),
      .peak_raw     (entry_ff.peak),
      .leds         (leds),
      .decay        (cfg.decay_factor),
      .sts          (walk_sts),
      .led_mask     (led_mask),
      .frame_mask   (frame_mask),
      .peak_decayed (peak_decayed)
   );

   // never-written entries read as reset values
   assign rd_entry = valid_ff[rd_addr_ff] ? entry_type'(ram_rdata) : RESET_ENTRY;

   assign ch_ok    = (32'(req_data.channel) < CHANNELS);
   assign emitted  = (32'(idx_ff) < EMIT_CNT);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cd_next  = (entry_ff.countdown != 8'd0) ? entry_ff.countdown - 8'd1 : 8'd0;

   always_comb begin
      state_in       = state_ff;
      ram_re         = 1'b0;
      rd_addr        = idx_ff;
      ram_we         = 1'b0;
      ram_waddr      = rd_addr_ff;
      wr_entry       = rd_entry;
      walk_ctl.start = 1'b0;
      load_out       = 1'b0;
      req_stall      = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.func == FUNC_LEVEL) begin
                  if (ch_ok) begin
                     ram_re   = 1'b1;
                     rd_addr  = AW'(req_data.channel);
                     state_in = S_LVL_RD;
                  end else if (req_data.frame_last) begin
                     state_in = S_EM_START;
                  end
               end else if (cfg.meter_enable) begin
                  state_in = S_EM_START;
               end
            end
         end
         S_LVL_RD: begin
            ram_we = 1'b1;
            if (level_ff > rd_entry.peak) begin
               wr_entry.peak = level_ff;
            end
            if (level_ff > rd_entry.hold) begin
               wr_entry.hold      = level_ff;
               wr_entry.countdown = cfg.hold_ticks;
            end
            state_in = last_ff ? S_EM_START : S_IDLE;
         end
         S_EM_START: begin
            ram_re   = 1'b1;
            state_in = S_EM_RD;
         end
         S_EM_RD: state_in = S_EM_GO;
         S_EM_GO: begin
            walk_ctl.start = 1'b1;
            state_in       = S_EM_WALK;
         end
         S_EM_WALK: begin
            if (walk_sts.done) begin
               state_in = S_EM_OUT;
            end
         end
         S_EM_OUT: begin
            // interlock: wait while the previous bar still sits in the output
            if (!emitted || out_free) begin
               load_out           = emitted;
               ram_we             = 1'b1;
               ram_waddr          = idx_ff;
               wr_entry.countdown = cd_next;
               wr_entry.hold      = (cd_next == 8'd0) ? entry_ff.peak : entry_ff.hold;
               wr_entry.peak      = tick_ff ? peak_decayed : entry_ff.peak;
               state_in           = (idx_ff == LAST_IDX) ? S_IDLE : S_EM_START;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ram_we) begin
            valid_ff[ram_waddr] <= 1'b1;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ram_re) begin
         rd_addr_ff <= rd_addr;
      end
      if (state_ff == S_IDLE && req_valid) begin
         tick_ff  <= (req_data.func == FUNC_TICK);
         last_ff  <= req_data.frame_last;
         level_ff <= req_data.level;
         idx_ff   <= '0;
      end else if (state_ff == S_EM_OUT && ram_we && idx_ff != LAST_IDX) begin
         idx_ff <= idx_ff + AW'(1);
      end
      if (state_ff == S_EM_RD) begin
         entry_ff <= rd_entry;
      end
      if (load_out) begin
         rsp_data_ff.bar_channel   <= 2'(idx_ff);
         rsp_data_ff.led_on_mask   <= led_mask;
         rsp_data_ff.frame_on_mask <= frame_mask;
         rsp_data_ff.last_bar      <= (idx_ff == LAST_EMIT);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_walk_done_in_walk: assert property (@(posedge clock) disable iff (reset)
      walk_sts.done |-> state_ff == S_EM_WALK)
      else $error("walker finished outside the walk state");

   a_out_interlock: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EM_OUT && emitted && rsp_valid_ff && rsp_stall)
      |=> state_ff == S_EM_OUT && $stable(idx_ff))
      else $error("bar advanced while the output register was full");

   // index is loaded on the beat that leaves idle
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> 32'(idx_ff) < CHANNELS)
      else $error("channel index out of range");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_LVL_RD || state_ff == S_EM_OUT))
      else $error("state memory written in an unexpected state");
`endif

endmodule

`default_nettype wire

>>> tb/led_bar_level_meter_peak_hold_tb.sv
// Testbench for the LED bar level meter: drives level and tick beats, rewrites the
// registers between phases and checks every bar beat against its own meter model.
// Depends on lbm_pkg and led_bar_level_meter_peak_hold.
`timescale 1ns / 1ps

module led_bar_level_meter_peak_hold_tb;
   import lbm_pkg::*;

   localparam int CHANNELS        = DEFAULT_CHANNELS;
   localparam int MAX_LEDS        = DEFAULT_MAX_LEDS;
   localparam int CLK_PERIOD      = 8;
   localparam int RESET_CYCLES    = 9;
   localparam int DRAIN_CYCLES    = 250;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int CYCLE_LIMIT     = 400000;

   // Meter model plus the queue of bars still owed by the block.
   class bar_scoreboard;
      logic [15:0] peak [CHANNELS];
      logic [15:0] hold [CHANNELS];
      logic [7:0]  countdown [CHANNELS];
      cfg_type     cfg;
      rsp_type     expected_bars [$];
      int          mismatches;
      int          bars_checked;

      function void reset_state();
         cfg.led_count    = RESET_LED_COUNT;
         cfg.hold_ticks   = RESET_HOLD_TICKS;
         cfg.decay_factor = RESET_DECAY;
         cfg.meter_enable = 1'b1;
         for (int i = 0; i < CHANNELS; i++) begin
            peak[i]      = FULL_SCALE;
            hold[i]      = FULL_SCALE;
            countdown[i] = RESET_HOLD_COUNT;
         end
      endfunction

      function void set_reg(reg_index_type idx, logic [15:0] value);
         case (idx)
            REG_LED_COUNT:  cfg.led_count    = value[5:0];
            REG_HOLD_TICKS: cfg.hold_ticks   = value[7:0];
            REG_DECAY:      cfg.decay_factor = value;
            REG_ENABLE:     cfg.meter_enable = value[0];
            default: ;
         endcase
      endfunction

      function logic [31:0] lit_mask(logic [15:0] v, int leds);
         logic [31:0] thr;
         logic [31:0] lvl;
         logic [31:0] mask;
         lvl  = (v >= FULL_NEAR) ? 32'(FULL_SCALE) : 32'(v);
         thr  = 32'(FULL_SCALE);
         mask = '0;
         for (int n = 0; n < leds; n++) begin
            if (lvl >= thr) mask[n] = 1'b1;
            thr = (thr * 32'(cfg.decay_factor)) >> 16;
         end
         return mask;
      endfunction

      function void predict_bars();
         int      leds;
         int      shown;
         rsp_type bar;
         leds  = (cfg.led_count > MAX_LEDS) ? MAX_LEDS : int'(cfg.led_count);
         shown = (CHANNELS < MAX_RESULTS) ? CHANNELS : MAX_RESULTS;
         for (int i = 0; i < CHANNELS; i++) begin
            if (i < shown) begin
               bar.bar_channel   = 2'(i);
               bar.led_on_mask   = lit_mask(peak[i], leds);
               bar.frame_on_mask = lit_mask(hold[i], leds);
               bar.last_bar      = (i == shown - 1);
               expected_bars.push_back(bar);
            end
            // countdown saturates at zero; at zero the hold tracks the peak
            if (countdown[i] != 0) countdown[i]--;
            if (countdown[i] == 0) hold[i] = peak[i];
         end
      endfunction

      // Returns 0 for a tick while disabled, which the block ignores.
      function int note_item(req_type item);
         if (func_type'(item.func) == FUNC_LEVEL) begin
            if (item.channel < CHANNELS) begin
               if (item.level > peak[item.channel]) peak[item.channel] = item.level;
               if (item.level > hold[item.channel]) begin
                  hold[item.channel]      = item.level;
                  countdown[item.channel] = cfg.hold_ticks;
               end
            end
            if (item.frame_last) predict_bars();
            return 1;
         end
         if (!cfg.meter_enable) return 0;
         predict_bars();
         for (int i = 0; i < CHANNELS; i++)
            peak[i] = 16'((32'(peak[i]) * 32'(cfg.decay_factor)) >> 16);
         return 1;
      endfunction

      function void report(string fld, logic [31:0] want, logic [31:0] got);
         $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
         mismatches++;
      endfunction

      function void check_bar(rsp_type got);
         rsp_type want;
         bars_checked++;
         if (expected_bars.size() == 0) begin
            $display("%0t: unexpected bar beat, expected none, actual %p", $time, got);
            mismatches++;
            return;
         end
         want = expected_bars.pop_front();
         if (got.bar_channel !== want.bar_channel)
            report("bar_channel", 32'(want.bar_channel), 32'(got.bar_channel));
         if (got.led_on_mask !== want.led_on_mask)
            report("led_on_mask", want.led_on_mask, got.led_on_mask);
         if (got.frame_on_mask !== want.frame_on_mask)
            report("frame_on_mask", want.frame_on_mask, got.frame_on_mask);
         if (got.last_bar !== want.last_bar)
            report("last_bar", 32'(want.last_bar), 32'(got.last_bar));
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_valid  = 1'b0;
   req_type     req_data   = '0;
   logic        rsp_stall  = 1'b0;
   logic        csr_valid  = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;
   logic        req_stall;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_ready;

   bar_scoreboard board;
   bit          calm = 1'b0;          // no random idling on either side while set
   int          hold_offs_asked = 0;
   int          hold_offs_done  = 0;
   int          sink_wait = 0;
   int          beats_sent = 0;
   int          acted_items = 0;
   int          settings_used = 0;
   int          cycle_count = 0;

   led_bar_level_meter_peak_hold #(
      .CHANNELS(CHANNELS),
      .MAX_LEDS(MAX_LEDS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Bar sink: checks accepted beats, stalls at random or for a requested long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_bar(rsp_data);
      if (hold_offs_done < hold_offs_asked) begin
         hold_offs_done++;
         sink_wait = HOLD_OFF_CYCLES;
         rsp_stall <= 1'b1;
      end else if (sink_wait > 0) begin
         sink_wait--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 12) begin
         sink_wait = $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("led_bar_level_meter_peak_hold test failed");
      $finish;
   end

   function automatic logic [15:0] pick_level();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return FULL_NEAR;
         3:       return FULL_SCALE;
         4:       return 16'($urandom_range(0, 255));
         5:       return FULL_NEAR - 16'($urandom_range(1, 4));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type random_item();
      logic [31:0] noise;
      noise = $urandom;
      return noise[$bits(req_type)-1:0];
   endfunction

   // Call at a clock edge; leaves valid high so the next beat can follow at once.
   task automatic send_item(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (board.note_item(item) != 0) acted_items++;
   endtask

   task automatic pause_maybe();
      if (!calm && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_level(input int ch, input logic [15:0] lvl, input bit last);
      req_type item;
      item.func       = FUNC_LEVEL;
      item.channel    = 2'(ch);
      item.level      = lvl;
      item.frame_last = last;
      send_item(item);
      pause_maybe();
   endtask

   task automatic send_tick();
      req_type item;
      item            = random_item();
      item.func       = FUNC_TICK;
      send_item(item);
      pause_maybe();
   endtask

   task automatic send_frame();
      int beats;
      beats = $urandom_range(1, 5);
      for (int k = 0; k < beats; k++)
         send_level($urandom_range(0, CHANNELS - 1), pick_level(), k == beats - 1);
   endtask

   // Mostly whole frames with random content, some ticks, some raw noise.
   task automatic run_random(input int target);
      int      start;
      int      roll;
      req_type item;
      start = acted_items;
      while (acted_items - start < target) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            send_frame();
         end else if (roll < 85) begin
            send_tick();
         end else begin
            item = random_item();
            send_item(item);
            pause_maybe();
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.expected_bars.size() != 0) @(posedge clock);
   endtask

   // Block may still be writing back channels after the last bar beat.
   task automatic settle();
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_reg(idx, value);
   endtask

   task automatic apply_settings(input logic [5:0] leds, input logic [7:0] ticks,
                                 input logic [15:0] decay, input logic enable);
      settle();
      write_reg(REG_LED_COUNT, {10'($urandom), leds});
      write_reg(REG_HOLD_TICKS, {8'($urandom), ticks});
      write_reg(REG_DECAY, decay);
      write_reg(REG_ENABLE, {15'($urandom), enable});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      board = new();
      board.reset_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: level extremes around full scale, frame end, ticks
      send_level(0, 16'hFFFF, 1'b0);
      send_level(1, FULL_NEAR, 1'b0);
      send_level(2, FULL_NEAR - 16'd1, 1'b0);
      send_level(3, 16'd0, 1'b1);
      send_tick();
      send_level(0, FULL_SCALE, 1'b1);
      send_level(1, 16'h5555, 1'b0);
      send_level(2, 16'hAAAA, 1'b0);
      send_level(3, 16'd1, 1'b1);
      send_tick();
      send_tick();
      send_level(3, 16'hFFFF, 1'b1);

      // longest bars, slowest decay, shortest nonzero hold
      apply_settings(6'd32, 8'd1, 16'hFFFF, 1'b1);
      send_tick();
      send_level(2, 16'd300, 1'b1);
      run_random(30);

      // one LED, longest hold, meter disabled: ticks ignored
      apply_settings(6'd1, 8'd255, 16'd1, 1'b0);
      send_tick();
      send_tick();
      send_level(1, 16'd40000, 1'b1);
      run_random(20);

      // zero LEDs, zero hold ticks, zero decay: a tick clears every peak
      apply_settings(6'd0, 8'd0, 16'd0, 1'b1);
      send_level(0, 16'd1000, 1'b0);
      send_tick();
      send_level(0, 16'd2, 1'b1);
      run_random(25);

      // LED count above the maximum saturates; hold the sink off so the block backs up
      apply_settings(6'd63, 8'd3, RESET_DECAY, 1'b1);
      calm <= 1'b1;
      hold_offs_asked <= hold_offs_asked + 1;
      for (int k = 0; k < 30; k++)
         send_level($urandom_range(0, CHANNELS - 1), pick_level(),
                    1'($urandom_range(0, 1)));
      drain();
      calm <= 1'b0;
      run_random(25);

      // random settings, one run of them with no idling at all
      apply_settings(6'($urandom_range(1, 32)), 8'($urandom_range(1, 8)), 16'($urandom), 1'b1);
      calm <= 1'b1;
      run_random(30);
      calm <= 1'b0;
      apply_settings(6'($urandom), 8'($urandom), 16'($urandom_range(30000, 65535)), 1'b1);
      run_random(30);

      settle();
      $display("Drove %0d request beats (%0d acted on) across %0d register settings;",
               beats_sent, acted_items, settings_used + 1);
      $display("checked %0d bar beats, %0d mismatches.", board.bars_checked,
               board.mismatches);
      if (board.mismatches == 0 && board.expected_bars.size() == 0) begin
         $display("led_bar_level_meter_peak_hold test passed");
      end else begin
         $display("led_bar_level_meter_peak_hold test failed");
      end
      $finish;
   end

endmodule
